// ----- rtl/pft_pkg.sv -----
// Shared types and constants for the packed field trace store.
// Holds the controller/datapath command and status structs and the per-word table.
// No dependencies.
`default_nettype none

package pft_pkg;

    localparam int unsigned WORD_BITS  = 64;
    localparam int unsigned WIDTH_W    = 7;
    localparam int unsigned POS_W      = 16;
    localparam int unsigned SHIFT_W    = 6;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned STEP_CNT_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_ELEM_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MODE = 2'd1;

    localparam logic [WIDTH_W-1:0] ELEM_WIDTH_RST = 7'd32;
    localparam logic [WIDTH_W-1:0] ELEM_WIDTH_MIN = 7'd1;
    localparam logic [WIDTH_W-1:0] ELEM_WIDTH_MAX = 7'd64;

    localparam logic [STEP_CNT_W-1:0] DIV_LAST = STEP_CNT_W'(POS_W - 1);

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    typedef struct packed {
        logic clear;
        logic start;
        logic step;
        logic calc;
        logic rd;
        logic wr;
        logic load_out;
    } pft_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic is_write;
        logic in_range;
        logic out_free;
    } pft_stat_t;

    // Elements per 64-bit word for an effective width of 1..64
    function automatic logic [WIDTH_W-1:0] per_word_of(input logic [WIDTH_W-1:0] w);
        logic [WIDTH_W-1:0] pw;
        case (w) inside
            7'd1:           pw = 7'd64;
            7'd2:           pw = 7'd32;
            7'd3:           pw = 7'd21;
            7'd4:           pw = 7'd16;
            7'd5:           pw = 7'd12;
            7'd6:           pw = 7'd10;
            7'd7:           pw = 7'd9;
            7'd8:           pw = 7'd8;
            7'd9:           pw = 7'd7;
            7'd10:          pw = 7'd6;
            [7'd11:7'd12]:  pw = 7'd5;
            [7'd13:7'd16]:  pw = 7'd4;
            [7'd17:7'd21]:  pw = 7'd3;
            [7'd22:7'd32]:  pw = 7'd2;
            default:        pw = 7'd1;
        endcase
        return pw;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/pft_ram.sv -----
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module pft_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 1024,
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [WIDTH-1:0]  wdata,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/pft_ctrl.sv -----
// Controller for the packed field trace store: sequences the store clear, divide,
// address, read and update. Depends on pft_pkg.
`default_nettype none

module pft_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire pft_pkg::pft_stat_t stat,
    output pft_pkg::pft_cmd_t      cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_CALC,
        S_READ,
        S_DONE
    } state_t;

    state_t                           state_reg;
    state_t                           state_next;
    logic [pft_pkg::STEP_CNT_W-1:0]   step_cnt_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (step_cnt_reg == pft_pkg::DIV_LAST)
                begin
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.is_write || stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            step_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_DIV)
            begin
                step_cnt_reg <= step_cnt_reg + 1'b1;
            end
            else
            begin
                step_cnt_reg <= '0;
            end
        end
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign cmd.clear    = (state_reg == S_CLEAR);
    assign cmd.start    = (state_reg == S_IDLE) && in_valid;
    assign cmd.step     = (state_reg == S_DIV);
    assign cmd.calc     = (state_reg == S_CALC);
    assign cmd.rd       = (state_reg == S_READ) && stat.in_range;
    assign cmd.wr       = (state_reg == S_DONE) && stat.is_write && stat.in_range;
    assign cmd.load_out = (state_reg == S_DONE) && !stat.is_write && stat.out_free;

endmodule

`default_nettype wire

// ----- rtl/pft_dp.sv -----
// Datapath for the packed field trace store: config registers, serial divider,
// field extract and merge, output register. Depends on pft_pkg and pft_ram.
`default_nettype none

module pft_dp #(
    parameter int unsigned WORD_COUNT = 1024
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [pft_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [pft_pkg::WIDTH_W-1:0]     cfg_data,
    input  wire logic                            kind,
    input  wire logic [pft_pkg::POS_W-1:0]       time_index,
    input  wire logic [pft_pkg::WORD_BITS-1:0]   write_value,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic      [pft_pkg::WORD_BITS-1:0]   read_value,
    input  wire pft_pkg::pft_cmd_t               cmd,
    output pft_pkg::pft_stat_t                   stat
);

    localparam int unsigned ADDR_W = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int unsigned WB     = pft_pkg::WORD_BITS;
    localparam int unsigned WW     = pft_pkg::WIDTH_W;
    localparam int unsigned PW     = pft_pkg::POS_W;
    localparam int unsigned SW     = pft_pkg::SHIFT_W;

    logic [WW-1:0]  elem_width_reg;
    logic           signed_mode_reg;

    logic           kind_reg;
    logic           sign_reg;
    logic [WB-1:0]  wval_reg;
    logic [WW-1:0]  eff_w_reg;
    logic [WW-1:0]  div_reg;
    logic [WW-1:0]  rem_reg;
    logic [PW-1:0]  quo_reg;
    logic [SW-1:0]  shift_reg;
    logic           in_range_reg;
    logic           out_valid_reg;
    logic [WB-1:0]  read_value_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    logic [WW-1:0]  eff_w;
    logic [WW:0]    trial;
    logic           trial_ge;
    logic [WW-1:0]  rem_next;
    logic [2*WW-1:0] shift_prod;
    logic           in_range_next;
    logic [WB-1:0]  mask;
    logic [WB-1:0]  ram_rdata;
    logic [WB-1:0]  ram_wdata;
    logic [WB-1:0]  ram_din;
    logic           ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [WB-1:0]  field;
    logic [WB-1:0]  field_ext;
    logic [SW-1:0]  sign_pos;

    // Saturate the configured width to 1..64
    always_comb
    begin
        if (elem_width_reg == '0)
        begin
            eff_w = pft_pkg::ELEM_WIDTH_MIN;
        end
        else if (elem_width_reg > pft_pkg::ELEM_WIDTH_MAX)
        begin
            eff_w = pft_pkg::ELEM_WIDTH_MAX;
        end
        else
        begin
            eff_w = elem_width_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elem_width_reg  <= pft_pkg::ELEM_WIDTH_RST;
            signed_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pft_pkg::REG_ELEM_WIDTH:  elem_width_reg  <= cfg_data;
                pft_pkg::REG_SIGNED_MODE: signed_mode_reg <= cfg_data[0];
                default:                  ;
            endcase
        end
    end

    // Advance the clear address, one word per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    // One quotient bit per step
    assign trial      = {rem_reg, quo_reg[PW-1]};
    assign trial_ge   = (trial >= {1'b0, div_reg});
    assign rem_next   = trial_ge ? WW'(trial - {1'b0, div_reg}) : WW'(trial);
    assign shift_prod = eff_w_reg * rem_reg;
    assign in_range_next = (32'(quo_reg) < 32'(WORD_COUNT));

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            kind_reg  <= kind;
            sign_reg  <= signed_mode_reg;
            wval_reg  <= write_value;
            eff_w_reg <= eff_w;
            div_reg   <= pft_pkg::per_word_of(eff_w);
            rem_reg   <= '0;
            quo_reg   <= time_index;
        end
        else if (cmd.step)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[PW-2:0], trial_ge};
        end
        if (cmd.calc)
        begin
            shift_reg    <= SW'(shift_prod);
            in_range_reg <= in_range_next;
        end
    end

    assign mask     = ~({WB{1'b1}} << eff_w_reg);
    assign field    = (ram_rdata >> shift_reg) & mask;
    assign sign_pos = SW'(eff_w_reg - 1'b1);

    always_comb
    begin
        field_ext = field;
        if (sign_reg && (eff_w_reg < pft_pkg::ELEM_WIDTH_MAX) && field[sign_pos])
        begin
            field_ext = field | ~mask;
        end
    end

    assign ram_wdata = (ram_rdata & ~(mask << shift_reg)) | ((wval_reg & mask) << shift_reg);
    assign ram_we    = cmd.wr || cmd.clear;
    assign ram_addr  = cmd.clear ? clr_addr_reg : ADDR_W'(quo_reg);
    assign ram_din   = cmd.clear ? '0 : ram_wdata;

    pft_ram #(
        .WIDTH (WB),
        .DEPTH (WORD_COUNT)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (cmd.rd),
        .addr  (ram_addr),
        .wdata (ram_din),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            read_value_reg <= in_range_reg ? field_ext : '0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign read_value      = read_value_reg;
    assign stat.clear_last = (clr_addr_reg == ADDR_W'(WORD_COUNT - 1));
    assign stat.is_write   = (kind_reg == pft_pkg::KIND_WRITE);
    assign stat.in_range   = in_range_reg;
    assign stat.out_free   = !out_valid_reg || out_ready;

endmodule

`default_nettype wire

// ----- rtl/packed_field_trace_store.sv -----
// Top level of the packed field trace store: controller plus datapath.
// Depends on pft_pkg, pft_ctrl, pft_dp (and pft_ram through pft_dp).
//
// Usage:
//   Input channel (in_valid/in_ready) carries one beat per access: kind selects
//   read or write, time_index the trace position, write_value the data to store.
//   A read yields one beat on the output channel (out_valid/out_ready) with the
//   element zero- or sign-extended in read_value; a write yields nothing.
//   Configuration: cfg_we with cfg_index 0 sets elem_width, index 1 signed_mode;
//   write only while the block is idle.
//   Sequence: a beat occupies the block until its last step ends, so no new beat
//   is accepted before then. The steps are the accept step, the bit-serial position
//   divider, the bit offset, one RAM read and one extract or merge step. in_ready
//   rises again after the last step, in the same cycle that a read result is first
//   held in the output register.
//   The output register frees the input: a new beat is accepted while a result
//   waits; if the receiver still stalls when the next read finishes, hold that
//   read in its last step until the register drains.
//   Reset clears control state and the configuration to width 32, unsigned; then
//   zero the store one word a cycle, all WORD_COUNT words (1024), with in_ready low.
`default_nettype none

module packed_field_trace_store #(
    parameter int unsigned WORD_COUNT = 1024
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            kind,
    input  wire logic [pft_pkg::POS_W-1:0]       time_index,
    input  wire logic [pft_pkg::WORD_BITS-1:0]   write_value,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic      [pft_pkg::WORD_BITS-1:0]   read_value,
    input  wire logic                            cfg_we,
    input  wire logic [pft_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [pft_pkg::WIDTH_W-1:0]     cfg_data
);

    pft_pkg::pft_cmd_t  cmd;
    pft_pkg::pft_stat_t stat;

    pft_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pft_dp #(
        .WORD_COUNT (WORD_COUNT)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .kind        (kind),
        .time_index  (time_index),
        .write_value (write_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .read_value  (read_value),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

`default_nettype wire
